FILE: rtl/sjed_pkg.sv
// Shared types, constants and table functions of the scan jump edge detector.
`timescale 1ns / 1ps
`default_nettype none

package sjed_pkg;

    // Default size of the asin table, as a power of two of the ratio steps.
    localparam int ASIN_TABLE_BITS_DEF = 10;
    localparam int HALF_PI_Q13         = 12868;
    localparam int CFG_IDX_W           = 3;
    localparam int CFG_DATA_W          = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_HALF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_HALF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_START  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP   = 3'd5;

    localparam logic signed [15:0] ANGLE_START_RST = -16'sd25736;

    typedef struct packed {
        logic [15:0] range_mm;
        logic        range_valid;
        logic        last_beam;
    } t_in;

    typedef struct packed {
        logic [15:0]        point_range_mm;
        logic signed [15:0] point_angle;
        logic signed [15:0] point_correction;
        logic               nearer_is_later;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic rom_read;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic out_free;
    } t_status;

    // Sine of a Q13 angle in Q30, by a nine term Taylor series.
    function automatic logic signed [63:0] sine_q30(input logic [13:0] a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t0, t1, t2, t3, t4, t5, t6, t7, t8;
        x  = 64'(a) << 17;
        x2 = (x * x) >> 30;
        t0 = x;
        t1 = ((t0 * x2) >> 30) / 64'd6;
        t2 = ((t1 * x2) >> 30) / 64'd20;
        t3 = ((t2 * x2) >> 30) / 64'd42;
        t4 = ((t3 * x2) >> 30) / 64'd72;
        t5 = ((t4 * x2) >> 30) / 64'd110;
        t6 = ((t5 * x2) >> 30) / 64'd156;
        t7 = ((t6 * x2) >> 30) / 64'd210;
        t8 = ((t7 * x2) >> 30) / 64'd272;
        return $signed(t0) - $signed(t1) + $signed(t2) - $signed(t3) + $signed(t4)
             - $signed(t5) + $signed(t6) - $signed(t7) + $signed(t8);
    endfunction

    // Smallest Q13 angle whose sine reaches idx / 2^bits, saturating at pi/2.
    function automatic logic [13:0] asin_entry(input int idx, input int bits);
        logic signed [63:0] target;
        logic [14:0]        lo;
        logic [14:0]        hi;
        logic [14:0]        mid;
        target = $signed(64'(idx) << (30 - bits));
        lo     = '0;
        hi     = 15'(HALF_PI_Q13);
        if (sine_q30(14'(HALF_PI_Q13)) < target) begin
            return 14'(HALF_PI_Q13);
        end
        for (int s = 0; s < 15; s++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (sine_q30(mid[13:0]) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 15'd1;
                end
            end
        end
        return lo[13:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/sjed_ctrl.sv
// Controller state machine that sequences one beam request through the datapath.
`timescale 1ns / 1ps
`default_nettype none

module sjed_ctrl #(
    parameter int ASIN_TABLE_BITS = sjed_pkg::ASIN_TABLE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  sjed_pkg::t_status i_status,
    output sjed_pkg::t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(ASIN_TABLE_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ASIN_TABLE_BITS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_cnt   = '0;
                n_state = i_status.hit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_cmd.capture    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.eval       = (r_state == S_EVAL);
    assign o_cmd.div_step   = (r_state == S_DIV);
    assign o_cmd.rom_read   = (r_state == S_LOOK);
    assign o_cmd.load_out   = (r_state == S_HOLD) && i_status.out_free;

    // A beam without a jump returns straight to idle after evaluation.
    a_no_hit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && !i_status.hit) |=> (r_state == S_IDLE))
        else $error("no-jump beam did not return to idle");

    // The table read always feeds the output hold state.
    a_look_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state == S_HOLD))
        else $error("table read not followed by hold");

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_LAST))
        else $error("divider step count overrun");

    // A new beam is only taken when no result is in flight.
    a_capture_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EVAL && !o_in_ready))
        else $error("capture did not start evaluation");

endmodule

`default_nettype wire

FILE: rtl/sjed_datapath.sv
// Datapath: configuration, previous beam state, jump test, divider, asin table, output.
`timescale 1ns / 1ps
`default_nettype none

module sjed_datapath #(
    parameter int ASIN_TABLE_BITS = sjed_pkg::ASIN_TABLE_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [sjed_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [sjed_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  sjed_pkg::t_in                        i_in,
    input  sjed_pkg::t_cmd                       i_cmd,
    output sjed_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output sjed_pkg::t_out                       o_out
);

    localparam int B       = ASIN_TABLE_BITS;
    localparam int ENTRIES = (1 << B) + 1;
    localparam logic [B:0] IDX_FULL = (B+1)'(1) << B;

    typedef logic [13:0] t_rom [ENTRIES];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < ENTRIES; i++) begin
            rom[i] = sjed_pkg::asin_entry(i, B);
        end
        return rom;
    endfunction

    localparam t_rom ASIN_ROM = build_rom();

    // Configuration registers.
    logic [15:0] r_front;
    logic [15:0] r_right;
    logic [15:0] r_left;
    logic [15:0] r_thresh;
    logic [15:0] r_angle_start;
    logic [12:0] r_angle_step;

    // Previous beam of the current scan.
    logic [15:0] r_prior_range;
    logic        r_prior_valid;
    logic        r_have_prior;
    logic [15:0] r_prior_angle;

    sjed_pkg::t_in r_in;

    // Pending result and divider.
    logic [15:0]  r_res_range;
    logic [15:0]  r_res_angle;
    logic         r_res_dir;
    logic [15:0]  r_den;
    logic [15:0]  r_rem;
    logic [B-1:0] r_quot;
    logic         r_sat;
    logic         r_zero;
    logic [13:0]  r_asin;

    logic           r_out_valid;
    sjed_pkg::t_out r_out;

    logic        cur_ok;
    logic [15:0] cur;
    logic [15:0] cur_angle;
    logic        pair_ok;
    logic        far_earlier;
    logic        far_later;
    logic [15:0] div_num;
    logic [15:0] div_den;
    logic [16:0] rem2;
    logic        rem_ge;
    logic [16:0] rem_sub;
    logic [B:0]  rom_idx;
    logic [14:0] corr_mag;
    logic [15:0] corr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front       <= '0;
            r_right       <= '0;
            r_left        <= '0;
            r_thresh      <= '0;
            r_angle_start <= sjed_pkg::ANGLE_START_RST;
            r_angle_step  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sjed_pkg::CFG_FRONT_OFFSET: r_front       <= i_cfg_data;
                sjed_pkg::CFG_RIGHT_HALF:   r_right       <= i_cfg_data;
                sjed_pkg::CFG_LEFT_HALF:    r_left        <= i_cfg_data;
                sjed_pkg::CFG_EDGE_THRESH:  r_thresh      <= i_cfg_data;
                sjed_pkg::CFG_ANGLE_START:  r_angle_start <= i_cfg_data;
                sjed_pkg::CFG_ANGLE_STEP:   r_angle_step  <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cur_ok      = r_in.range_valid && (r_in.range_mm >= r_front);
        cur         = cur_ok ? (r_in.range_mm - r_front) : 16'd0;
        cur_angle   = r_have_prior ? (r_prior_angle + {3'b000, r_angle_step}) : r_angle_start;
        pair_ok     = r_have_prior && r_prior_valid && cur_ok
                      && (r_prior_range >= r_left) && (cur >= r_left);
        far_earlier = {1'b0, r_prior_range} > ({1'b0, cur} + {1'b0, r_thresh});
        far_later   = {1'b0, cur} > ({1'b0, r_prior_range} + {1'b0, r_thresh});
        div_num     = far_earlier ? r_right : r_left;
        div_den     = far_earlier ? cur : r_prior_range;
    end

    assign o_status.hit      = pair_ok && (far_earlier || far_later);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Restoring division step: one fraction bit of num / den per cycle.
    assign rem2    = {r_rem, 1'b0};
    assign rem_ge  = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_range <= '0;
            r_prior_valid <= 1'b0;
            r_have_prior  <= 1'b0;
            r_prior_angle <= '0;
        end else if (i_cmd.eval) begin
            if (r_in.last_beam) begin
                r_prior_range <= '0;
                r_prior_valid <= 1'b0;
                r_have_prior  <= 1'b0;
                r_prior_angle <= '0;
            end else begin
                r_prior_range <= cur;
                r_prior_valid <= cur_ok;
                r_have_prior  <= 1'b1;
                r_prior_angle <= cur_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in;
        end
        if (i_cmd.eval) begin
            r_res_range <= far_earlier ? cur : r_prior_range;
            r_res_angle <= far_earlier ? r_prior_angle : cur_angle;
            r_res_dir   <= far_earlier;
            r_den       <= div_den;
            r_rem       <= div_num;
            r_quot      <= '0;
            // A ratio of one or more saturates; zero over zero counts as zero.
            r_zero      <= (div_num == 16'd0) && (div_den == 16'd0);
            r_sat       <= div_num >= div_den;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_sub[15:0] : rem2[15:0];
            r_quot <= {r_quot[B-2:0], rem_ge};
        end
        if (i_cmd.rom_read) begin
            r_asin <= ASIN_ROM[rom_idx];
        end
    end

    always_comb begin
        if (r_zero) begin
            rom_idx = '0;
        end else if (r_sat) begin
            rom_idx = IDX_FULL;
        end else begin
            rom_idx = {1'b0, r_quot};
        end
    end

    assign corr_mag = {r_asin, 1'b0};
    assign corr     = r_res_dir ? (16'd0 - {1'b0, corr_mag}) : {1'b0, corr_mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.point_range_mm   <= r_res_range;
            r_out.point_angle      <= r_res_angle;
            r_out.point_correction <= corr;
            r_out.nearer_is_later  <= r_res_dir;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: rtl/scan_jump_edge_detector_top.sv
// Top level of the scan jump edge detector: controller plus datapath.
`timescale 1ns / 1ps
`default_nettype none

// The block takes laser range requests of a scan in beam order, subtracts the
// front offset, and compares each beam with the previous beam of the same scan.
// A beam marked last closes the scan, and the next beam starts a new one with
// the start angle. When the offset ranges of two usable neighbors differ by
// more than the edge threshold, one result request is produced with the nearer
// range, the beam angle of the jump and a correction of twice the arcsine of
// the relevant half width over that range, in Q13 radians with the sign of the
// side. A beam that causes no result goes from evaluation back to idle, where
// the input is ready again. A beam that causes a result passes through the
// restoring divider, which forms one ratio bit per cycle, and then one
// registered read of the asin table. The result sits in an output register, so
// the block can take the next beam while a result waits; it stalls only when a
// second result is ready before the first has been taken. Configuration is
// written through a plain write port and takes effect at once; write it only
// while the block is idle.

module scan_jump_edge_detector_top #(
    parameter int ASIN_TABLE_BITS = sjed_pkg::ASIN_TABLE_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire  [sjed_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [sjed_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  sjed_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output sjed_pkg::t_out                   o_out
);

    sjed_pkg::t_cmd    cmd;
    sjed_pkg::t_status status;

    // The controller walks each request through evaluate and, on a jump, divide, lookup and hold.
    sjed_ctrl #(
        .ASIN_TABLE_BITS (ASIN_TABLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds configuration, the previous beam and the result register.
    sjed_datapath #(
        .ASIN_TABLE_BITS (ASIN_TABLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
